// ===== src/hfpt_pkg.sv =====
// Package for the hashed flow packet table: geometry, status codes, beat types.
// No dependencies.
`default_nettype none
package hfpt_pkg;
  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = 32 + 32 + 32 + 8 + 32;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_SINGLE = 3'd4;
  localparam logic [2:0] ST_MULTI = 3'd5;

  typedef struct packed {
    logic        action;
    logic [7:0]  bucket;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pkt_count;
  } out_item_t;

  // Request handed from front end to back end
  typedef struct packed {
    logic             action;
    logic [BKT_W-1:0] bkt;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [7:0]       proto;
    logic [31:0]      ports;
  } req_t;
endpackage
`default_nettype wire

// ===== src/hfpt_front.sv =====
// Front end: accepts input beats, reduces the bucket and packs the tuple.
// Depends on hfpt_pkg.
`default_nettype none
module hfpt_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  hfpt_pkg::in_item_t  in_data,
  output logic                req_valid,
  input  wire logic           req_ready,
  output hfpt_pkg::req_t      req
);
  import hfpt_pkg::*;

  logic [8+BKT_W-1:0] bkt_wide;

  assign bkt_wide = {{BKT_W{1'b0}}, in_data.bucket} % (8+BKT_W)'(BUCKETS);
  assign in_ready = !req_valid || req_ready;

  // Hold one classified request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.action <= in_data.action;
      req.bkt    <= bkt_wide[BKT_W-1:0];
      req.src    <= in_data.src_addr;
      req.dst    <= in_data.dst_addr;
      req.proto  <= in_data.proto;
      req.ports  <= {in_data.src_port, in_data.dst_port};
    end
  end
endmodule
`default_nettype wire

// ===== src/hfpt_queue.sv =====
// Two-entry queue between front and back end.
// Depends on hfpt_pkg.
`default_nettype none
module hfpt_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  hfpt_pkg::req_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output hfpt_pkg::req_t rd_data
);
  import hfpt_pkg::*;

  req_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data  = slot[rptr];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== src/hfpt_back.sv =====
// Back end: bucket read, match, write-back and result register.
// Depends on hfpt_pkg.
`default_nettype none
module hfpt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  hfpt_pkg::req_t     req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hfpt_pkg::out_item_t out_data
);
  import hfpt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;

  // One memory row holds all ways of a bucket
  logic [ENTRY_W-1:0] mem [BUCKETS][WAYS];
  logic [ENTRY_W-1:0] row [WAYS];
  logic [WAYS-1:0]    vbits [BUCKETS];
  logic [WAYS-1:0]    vrow;
  logic [BKT_W:0]     clr_idx;
  logic               clearing;
  logic [1:0]         state;
  req_t               cur;

  logic [WAYS-1:0]    hit_vec;
  logic               found;
  logic               have_free;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   free_way;
  logic [31:0]        hit_count;
  logic [31:0]        new_count;
  logic               do_write;
  logic [WAY_W-1:0]   wr_way;
  logic [ENTRY_W-1:0] wr_entry;
  out_item_t          res;

  assign req_ready = !clearing && state == S_IDLE && (!out_valid || out_ready);

  // Find first matching and first free way
  always_comb begin
    found = 1'b0;
    have_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    hit_count = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vrow[w] && row[w] == {cur.src, cur.dst, cur.ports, cur.proto,
                                         row[w][31:0]};
      if (!found && hit_vec[w]) begin
        found = 1'b1;
        hit_way = WAY_W'(w);
        hit_count = row[w][31:0];
      end
      if (!have_free && !vrow[w]) begin
        have_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  assign new_count = (hit_count == 32'hFFFF_FFFF) ? hit_count : hit_count + 32'd1;

  // Decide result and write-back
  always_comb begin
    do_write = 1'b0;
    wr_way = hit_way;
    wr_entry = {cur.src, cur.dst, cur.ports, cur.proto, new_count};
    res.status = ST_NOT_FOUND;
    res.pkt_count = '0;
    if (cur.action == ACT_SEARCH) begin
      if (found) begin
        res.status = (hit_count == 32'd1) ? ST_SINGLE : ST_MULTI;
        res.pkt_count = hit_count;
      end
    end else if (found) begin
      do_write = 1'b1;
      res.status = ST_COUNTED;
      res.pkt_count = new_count;
    end else if (have_free) begin
      do_write = 1'b1;
      wr_way = free_way;
      wr_entry = {cur.src, cur.dst, cur.ports, cur.proto, 32'd1};
      res.status = ST_INSERTED;
      res.pkt_count = 32'd1;
    end else begin
      res.status = ST_FULL;
    end
  end

  // Sequence: clear valid rows, read bucket, evaluate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clearing <= 1'b1;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == (BKT_W+1)'(BUCKETS - 1)) clearing <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (req_valid && req_ready) state <= S_EVAL;
        S_EVAL: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid && req_ready) begin
      cur <= req;
      vrow <= vbits[req.bkt];
      for (int w = 0; w < WAYS; w++) row[w] <= mem[req.bkt][w];
    end
    if (clearing) vbits[clr_idx[BKT_W-1:0]] <= '0;
    if (state == S_EVAL) begin
      out_data <= res;
      if (do_write) begin
        mem[cur.bkt][wr_way] <= wr_entry;
        vbits[cur.bkt][wr_way] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/hashed_flow_packet_table.sv =====
// Hashed flow packet table top level: front end, queue and back end.
// Depends on hfpt_pkg, hfpt_front, hfpt_queue, hfpt_back.
// Each beat goes through a bucket row read, then match and write-back of one
// entry, plus output handshake; one item at a time in the back end. After
// reset a clearing pass zeroes the valid bits one bucket per cycle before the
// first item is taken.
`default_nettype none
module hashed_flow_packet_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  hfpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hfpt_pkg::out_item_t out_data
);
  import hfpt_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  req_t f_req, q_req;

  hfpt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  hfpt_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  hfpt_back u_back (
    .clk, .rst, .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
